// ===== src/bstk_pkg.sv =====
// Shared types and codes for the bounded stack with sort.
// Used by bstk_ctrl, bstk_dp and the top level; depends on nothing.
package bstk_pkg;

  localparam int DEPTH_DEF      = 10;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 2;
  localparam int FILL_W         = 4;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_SORT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] pop_value;
    logic [STATUS_W-1:0]       status;
    logic [FILL_W-1:0]         fill_count;
  } out_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_PUSH,
    DP_EMPTY,
    DP_DONE,
    DP_POP_START,
    DP_POP_DONE,
    DP_SORT_START,
    DP_SORT_LOAD,
    DP_SORT_SHIFT,
    DP_SORT_PLACE
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic small_fill;
    logic less;
    logic slot_one;
    logic more;
  } dp_stat_t;

endpackage

// ===== src/bstk_dp.sv =====
// Datapath: entry memory, fill count, sort indices and the result register.
// Executes commands from bstk_ctrl; depends on bstk_pkg.
module bstk_dp #(
  parameter int DEPTH      = bstk_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bstk_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bstk_pkg::dp_cmd_t           cmd,
  input  logic signed [bstk_pkg::VALUE_W-1:0] push_value,
  output bstk_pkg::dp_stat_t          stat,
  output bstk_pkg::out_t              out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [DATA_WIDTH-1:0] held_r, held_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [IW-1:0]         slot_r, slot_nxt;
  bstk_pkg::out_t        out_r, out_nxt;

  logic                  we;
  logic [IW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [CW-1:0]         count_inc, count_dec, i_inc_c;

  assign count_inc = count_r + CW'(1);
  assign count_dec = count_r - CW'(1);
  assign i_inc_c   = CW'(i_r) + CW'(1);

  assign stat.count_zero = (count_r == '0);
  assign stat.full       = (count_r == CW'(DEPTH));
  assign stat.small_fill = (count_r <= CW'(1));
  assign stat.less       = ($signed(held_r) < $signed(rdata_r));
  assign stat.slot_one   = (slot_r == IW'(1));
  assign stat.more       = (i_inc_c < count_r);

  assign out_data = out_r;

  always_comb begin
    count_nxt = count_r;
    i_nxt     = i_r;
    slot_nxt  = slot_r;
    held_nxt  = held_r;
    out_nxt   = out_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = rdata_r;
    raddr     = '0;
    case (cmd)
      bstk_pkg::DP_PUSH: begin
        out_nxt.pop_value = '0;
        if (stat.full) begin
          out_nxt.status     = bstk_pkg::ST_FULL;
          out_nxt.fill_count = bstk_pkg::FILL_W'(count_r);
        end else begin
          we                 = 1'b1;
          waddr              = IW'(count_r);
          wdata              = DATA_WIDTH'($unsigned(push_value));
          count_nxt          = count_inc;
          out_nxt.status     = bstk_pkg::ST_DONE;
          out_nxt.fill_count = bstk_pkg::FILL_W'(count_inc);
        end
      end
      bstk_pkg::DP_EMPTY: begin
        out_nxt.pop_value  = '0;
        out_nxt.status     = bstk_pkg::ST_EMPTY;
        out_nxt.fill_count = bstk_pkg::FILL_W'(count_r);
      end
      bstk_pkg::DP_DONE: begin
        out_nxt.pop_value  = '0;
        out_nxt.status     = bstk_pkg::ST_DONE;
        out_nxt.fill_count = bstk_pkg::FILL_W'(count_r);
      end
      bstk_pkg::DP_POP_START: begin
        raddr     = IW'(count_dec);
        count_nxt = count_dec;
      end
      bstk_pkg::DP_POP_DONE: begin
        out_nxt.pop_value  = bstk_pkg::VALUE_W'(rdata_r);
        out_nxt.status     = bstk_pkg::ST_DONE;
        out_nxt.fill_count = bstk_pkg::FILL_W'(count_r);
      end
      bstk_pkg::DP_SORT_START: begin
        i_nxt = IW'(1);
        raddr = IW'(1);
      end
      bstk_pkg::DP_SORT_LOAD: begin
        held_nxt = rdata_r;
        slot_nxt = i_r;
        raddr    = i_r - IW'(1);
      end
      bstk_pkg::DP_SORT_SHIFT: begin
        we       = 1'b1;
        waddr    = slot_r;
        wdata    = rdata_r;
        slot_nxt = slot_r - IW'(1);
        raddr    = stat.slot_one ? '0 : slot_r - IW'(2);
      end
      bstk_pkg::DP_SORT_PLACE: begin
        we    = 1'b1;
        waddr = slot_r;
        wdata = held_r;
        i_nxt = i_r + IW'(1);
        raddr = stat.more ? IW'(i_inc_c) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    i_r    <= i_nxt;
    slot_r <= slot_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== src/bstk_ctrl.sv =====
// Controller: sequences push, pop and the insertion sort, owns the handshakes.
// Drives bstk_dp through commands; depends on bstk_pkg.
module bstk_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bstk_pkg::OP_W-1:0]    in_op,
  output logic                         out_valid,
  input  logic                         out_stall,
  input  bstk_pkg::dp_stat_t           stat,
  output bstk_pkg::dp_cmd_t            cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_LOAD,
    S_CMP,
    S_PLACE,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, respond;

  assign in_stall  = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = bstk_pkg::DP_NONE;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            bstk_pkg::OP_PUSH: cmd = bstk_pkg::DP_PUSH;
            bstk_pkg::OP_POP: begin
              if (stat.count_zero) begin
                cmd = bstk_pkg::DP_EMPTY;
              end else begin
                cmd       = bstk_pkg::DP_POP_START;
                state_nxt = S_POP;
              end
            end
            bstk_pkg::OP_SORT: begin
              if (stat.small_fill) begin
                cmd = bstk_pkg::DP_DONE;
              end else begin
                cmd       = bstk_pkg::DP_SORT_START;
                state_nxt = S_LOAD;
              end
            end
            default: cmd = bstk_pkg::DP_DONE;
          endcase
        end
      end
      S_POP: begin
        cmd       = bstk_pkg::DP_POP_DONE;
        state_nxt = S_IDLE;
      end
      S_LOAD: begin
        cmd       = bstk_pkg::DP_SORT_LOAD;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.less) begin
          cmd       = bstk_pkg::DP_SORT_SHIFT;
          state_nxt = stat.slot_one ? S_PLACE : S_CMP;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd       = bstk_pkg::DP_SORT_PLACE;
        state_nxt = stat.more ? S_LOAD : S_FIN;
      end
      S_FIN: begin
        cmd       = bstk_pkg::DP_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign respond = (cmd == bstk_pkg::DP_PUSH) || (cmd == bstk_pkg::DP_EMPTY) ||
                   (cmd == bstk_pkg::DP_DONE) || (cmd == bstk_pkg::DP_POP_DONE);

  always_comb begin
    out_valid_nxt = respond ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/bounded_stack_with_sort.sv =====
// Top level of the bounded stack with in-place insertion sort.
// Joins bstk_ctrl and bstk_dp; depends on bstk_pkg.
//
//   channel | ports                          | payload
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_stall, in_data    | op, push_value
//   result  | out_valid, out_stall, out_data | pop_value, status, fill_count
//
// Push, refused pop, sort of fewer than two entries and unused ops are answered straight from the idle state.
// Pop passes through S_POP for the registered read of the single-read-port entry memory.
// Sort of n entries: for each entry i=1..n-1 the states S_LOAD, S_CMP (held while it
// shifts) and S_PLACE, then S_FIN; one compare-shift per cycle.
// Reset clears the fill count but not the entries; entries need no clearing pass.
// A waiting result stalls new transactions only while out_stall is high.
module bounded_stack_with_sort #(
  parameter int DEPTH      = bstk_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bstk_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bstk_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bstk_pkg::out_t out_data
);

  bstk_pkg::dp_cmd_t  cmd;
  bstk_pkg::dp_stat_t stat;

  bstk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bstk_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .push_value (in_data.push_value),
    .stat       (stat),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == bstk_pkg::DP_PUSH && stat.full) |=> (out_data.status == bstk_pkg::ST_FULL))
    else $error("full push not reported as full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == bstk_pkg::DP_POP_START) |-> !stat.count_zero)
    else $error("pop started on empty stack");

  a_pop_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == bstk_pkg::DP_POP_START) |=> (cmd == bstk_pkg::DP_POP_DONE && !out_valid))
    else $error("pop read not followed by pop completion");
`endif

endmodule
